/* hw/rtl/fnc_pkg.sv */
// Shared types and constants for the fuzzy norm combiner.
`timescale 1ns / 1ps

package fnc_pkg;

  localparam int unsigned KEY_W        = 16;
  localparam int unsigned DEG_W        = 17;
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned SUM_W        = DEG_W + 1;
  localparam int unsigned AB_W         = 33;
  localparam int unsigned NUM_W        = 50;
  localparam int unsigned DEN_W        = 34;
  localparam int unsigned QUO_W        = 17;
  localparam int unsigned SET_SIZE_MAX = 1024;

  localparam logic [DEG_W-1:0] FX_ONE = DEG_W'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_MIN   = 3'd0,
    OP_PROD  = 3'd1,
    OP_EPROD = 3'd2,
    OP_DPROD = 3'd3,
    OP_MAX   = 3'd4,
    OP_PSUM  = 3'd5,
    OP_ESUM  = 3'd6,
    OP_DSUM  = 3'd7
  } op_t;

  // Fields that ride alongside the divider stages.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
    logic             bad;
    op_t              op;
    logic [DEG_W-1:0] simple;
  } side_t;

endpackage

/* hw/rtl/fnc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps

module fnc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [fnc_pkg::NUM_W-1:0] num,
  input  logic [fnc_pkg::DEN_W-1:0] den,
  input  fnc_pkg::side_t           side_in,
  output logic                     out_valid,
  output logic [fnc_pkg::QUO_W-1:0] quo,
  output fnc_pkg::side_t           side_out
);
  import fnc_pkg::*;

  logic             v_r    [QUO_W];
  logic [NUM_W-1:0] rem_r  [QUO_W];
  logic [DEN_W-1:0] den_r  [QUO_W];
  logic [QUO_W-1:0] q_r    [QUO_W];
  side_t            side_r [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic             v_prev;
    logic [NUM_W-1:0] rem_prev;
    logic [DEN_W-1:0] den_prev;
    logic [QUO_W-1:0] q_prev;
    side_t            side_prev;
    logic [NUM_W-1:0] den_sh;
    logic [NUM_W:0]   diff;

    if (j == 0) begin : g_first
      assign v_prev    = in_valid;
      assign rem_prev  = num;
      assign den_prev  = den;
      assign q_prev    = '0;
      assign side_prev = side_in;
    end else begin : g_next
      assign v_prev    = v_r[j-1];
      assign rem_prev  = rem_r[j-1];
      assign den_prev  = den_r[j-1];
      assign q_prev    = q_r[j-1];
      assign side_prev = side_r[j-1];
    end

    assign den_sh = NUM_W'(den_prev) << (QUO_W - 1 - j);
    assign diff   = {1'b0, rem_prev} - {1'b0, den_sh};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j]  <= den_prev;
        side_r[j] <= side_prev;
        if (diff[NUM_W]) begin
          rem_r[j] <= rem_prev;
          q_r[j]   <= q_prev;
        end else begin
          rem_r[j] <= diff[NUM_W-1:0];
          q_r[j]   <= q_prev | (QUO_W'(1) << (QUO_W - 1 - j));
        end
      end
    end
  end

  assign out_valid = v_r[QUO_W-1];
  assign quo       = q_r[QUO_W-1];
  assign side_out  = side_r[QUO_W-1];

endmodule

/* hw/rtl/fuzzy_norm_combiner.sv */
// Top level: fuzzy t-norm / s-norm combiner, one element pair per transfer.
//
//  channel | direction | handshake            | payload
//  in      | in        | in_valid / in_stall   | key_a key_b degree_a degree_b count_a count_b is_last
//  out     | out       | out_valid / out_stall | key_out degree_out mismatch last_out
//  cfg     | in        | cfg_we                | cfg_data (operation)
//
// One transfer per cycle in each direction unless the pipeline is stalled; stages are input,
// multiply, prepare, 17 divider stages, output. The 17-stage restoring divider sets the depth.
// Synchronous reset empties the pipeline and sets the operation to minimum.
// A stalled result freezes the whole pipeline; in_stall is raised while it waits.
`timescale 1ns / 1ps

module fuzzy_norm_combiner (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fnc_pkg::OP_W-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fnc_pkg::KEY_W-1:0]   key_a,
  input  logic [fnc_pkg::KEY_W-1:0]   key_b,
  input  logic [fnc_pkg::DEG_W-1:0]   degree_a,
  input  logic [fnc_pkg::DEG_W-1:0]   degree_b,
  input  logic [fnc_pkg::CNT_W-1:0]   count_a,
  input  logic [fnc_pkg::CNT_W-1:0]   count_b,
  input  logic                        is_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fnc_pkg::KEY_W-1:0]   key_out,
  output logic [fnc_pkg::DEG_W-1:0]   degree_out,
  output logic                        mismatch,
  output logic                        last_out
);
  import fnc_pkg::*;

  op_t operation;

  logic en;

  // stage 0
  logic             v0;
  logic [DEG_W-1:0] a0, b0;
  logic [KEY_W-1:0] key0;
  logic             last0, bad0;
  op_t              op0;
  logic [DEG_W-1:0] a_in, b_in;
  logic             bad_in;

  // stage 1
  logic             v1;
  logic [DEG_W-1:0] a1, b1;
  logic [AB_W-1:0]  ab1;
  logic [KEY_W-1:0] key1;
  logic             last1, bad1;
  op_t              op1;

  // stage 2
  logic             v2;
  logic [NUM_W-1:0] num2;
  logic [DEN_W-1:0] den2;
  side_t            side2;
  logic [SUM_W-1:0] sum1;
  logic [NUM_W-1:0] num_next;
  logic [DEN_W-1:0] den_next;
  logic [DEG_W-1:0] simple_next;
  logic [AB_W+1:0]  den_ep;
  logic [AB_W+1:0]  psum;

  // divider output
  logic             div_valid;
  logic [QUO_W-1:0] div_quo;
  side_t            div_side;
  logic [DEG_W-1:0] pick;
  logic [DEG_W-1:0] degree_next;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= OP_MIN;
    end else if (cfg_we) begin
      operation <= op_t'(cfg_data);
    end
  end

  // stage 0: saturate degrees, check keys and sizes
  assign a_in   = (degree_a > FX_ONE) ? FX_ONE : degree_a;
  assign b_in   = (degree_b > FX_ONE) ? FX_ONE : degree_b;
  assign bad_in = (key_a != key_b) || (count_a != count_b) ||
                  (32'(count_a) > SET_SIZE_MAX) || (32'(count_b) > SET_SIZE_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0    <= a_in;
      b0    <= b_in;
      key0  <= key_a;
      last0 <= is_last;
      bad0  <= bad_in;
      op0   <= operation;
    end
  end

  // stage 1: product
  always_ff @(posedge clk) begin
    if (en) begin
      ab1   <= AB_W'(a0) * AB_W'(b0);
      a1    <= a0;
      b1    <= b0;
      key1  <= key0;
      last1 <= last0;
      bad1  <= bad0;
      op1   <= op0;
    end
  end

  // stage 2: direct results and divider operands
  assign sum1   = {1'b0, a1} + {1'b0, b1};
  assign den_ep = ((AB_W+2)'(1) << 33) + (AB_W+2)'(ab1) - ((AB_W+2)'(sum1) << 16);
  assign psum   = ((AB_W+2)'(sum1) << 16) - (AB_W+2)'(ab1);

  always_comb begin
    num_next    = '0;
    den_next    = DEN_W'(1);
    simple_next = '0;
    case (op1)
      OP_MIN:   simple_next = (a1 < b1) ? a1 : b1;
      OP_PROD:  simple_next = ab1[AB_W-1:16];
      OP_EPROD: begin
        num_next = NUM_W'(ab1) << 16;
        den_next = den_ep[DEN_W-1:0];
      end
      OP_DPROD: begin
        if (b1 == FX_ONE) begin
          simple_next = a1;
        end else if (a1 == FX_ONE) begin
          simple_next = b1;
        end
      end
      OP_MAX:   simple_next = (a1 > b1) ? a1 : b1;
      OP_PSUM:  simple_next = psum[16 +: DEG_W];
      OP_ESUM: begin
        num_next = NUM_W'(sum1) << 32;
        den_next = (DEN_W'(1) << 32) + DEN_W'(ab1);
      end
      default: begin
        if (b1 == '0) begin
          simple_next = a1;
        end else if (a1 == '0) begin
          simple_next = b1;
        end else begin
          simple_next = FX_ONE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2         <= num_next;
      den2         <= den_next;
      side2.key    <= key1;
      side2.last   <= last1;
      side2.bad    <= bad1;
      side2.op     <= op1;
      side2.simple <= simple_next;
    end
  end

  fnc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .num       (num2),
    .den       (den2),
    .side_in   (side2),
    .out_valid (div_valid),
    .quo       (div_quo),
    .side_out  (div_side)
  );

  // output register
  assign pick = (div_side.op == OP_EPROD || div_side.op == OP_ESUM) ?
                DEG_W'(div_quo) : div_side.simple;

  always_comb begin
    if (div_side.bad) begin
      degree_next = '0;
    end else if (pick > FX_ONE) begin
      degree_next = FX_ONE;
    end else begin
      degree_next = pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key_out    <= div_side.key;
      degree_out <= degree_next;
      mismatch   <= div_side.bad;
      last_out   <= div_side.last;
    end
  end

  a_mismatch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && mismatch |-> degree_out == '0)
    else $error("mismatch result with nonzero degree");

  a_degree_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> degree_out <= FX_ONE)
    else $error("degree above one");

  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    div_valid && (div_side.op == OP_EPROD || div_side.op == OP_ESUM) |->
      DEG_W'(div_quo) <= FX_ONE)
    else $error("divider quotient above one");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(div_side) && $stable(div_valid))
    else $error("pipeline moved while result stalled");

endmodule

/* tb/tb_fuzzy_norm_combiner.sv */
// Testbench for the fuzzy norm combiner: directed table then randomised transfers.
`timescale 1ns / 1ps

module tb_fuzzy_norm_combiner;
  import fnc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 30;
  localparam int unsigned PHASE_ITEMS = 80;

  typedef struct packed {
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
    logic [DEG_W-1:0] deg_a;
    logic [DEG_W-1:0] deg_b;
    logic [CNT_W-1:0] cnt_a;
    logic [CNT_W-1:0] cnt_b;
    logic             last;
  } pair_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [DEG_W-1:0] degree;
    logic             mismatch;
    logic             last;
  } result_t;

  typedef struct packed {
    op_t              op;
    pair_t            pair;
    logic             typed;
    logic [DEG_W-1:0] exp_deg;
    logic             exp_mis;
  } row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [OP_W-1:0]  cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [KEY_W-1:0] key_a = '0;
  logic [KEY_W-1:0] key_b = '0;
  logic [DEG_W-1:0] degree_a = '0;
  logic [DEG_W-1:0] degree_b = '0;
  logic [CNT_W-1:0] count_a = '0;
  logic [CNT_W-1:0] count_b = '0;
  logic             is_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [KEY_W-1:0] key_out;
  logic [DEG_W-1:0] degree_out;
  logic             mismatch;
  logic             last_out;

  result_t     pending_results[$];
  result_t     head;
  op_t         op_now = OP_MIN;
  int          fail_count = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int unsigned cycle_cnt = 0;

  // op, {key_a, key_b, deg_a, deg_b, cnt_a, cnt_b, last}, typed, degree, mismatch
  row_t directed_rows [25] = '{
    '{OP_MIN,   '{16'h0000, 16'h0000, 17'd0, 17'd65536, 11'd0, 11'd0, 1'b0},
      1'b1, 17'd0, 1'b0},
    '{OP_MIN,   '{16'hFFFF, 16'hFFFF, 17'h1FFFF, 17'h1FFFF, 11'd1024, 11'd1024, 1'b1},
      1'b1, 17'd65536, 1'b0},
    '{OP_MIN,   '{16'h1234, 16'h1235, 17'd40000, 17'd40000, 11'd10, 11'd10, 1'b0},
      1'b1, 17'd0, 1'b1},
    '{OP_MIN,   '{16'h0007, 16'h0007, 17'd40000, 17'd40000, 11'd10, 11'd11, 1'b0},
      1'b1, 17'd0, 1'b1},
    '{OP_MIN,   '{16'h0007, 16'h0007, 17'd40000, 17'd40000, 11'd2047, 11'd2047, 1'b1},
      1'b1, 17'd0, 1'b1},
    '{OP_MIN,   '{16'h0007, 16'h0007, 17'd40000, 17'd40000, 11'd1025, 11'd1025, 1'b0},
      1'b1, 17'd0, 1'b1},
    '{OP_PROD,  '{16'h0001, 16'h0001, 17'd65536, 17'd65536, 11'd5, 11'd5, 1'b0},
      1'b1, 17'd65536, 1'b0},
    '{OP_PROD,  '{16'h0002, 16'h0002, 17'd32768, 17'd32768, 11'd5, 11'd5, 1'b0},
      1'b1, 17'd16384, 1'b0},
    '{OP_PROD,  '{16'h0003, 16'h0003, 17'd12345, 17'd54321, 11'd5, 11'd5, 1'b1},
      1'b0, 17'd0, 1'b0},
    '{OP_EPROD, '{16'h0004, 16'h0004, 17'd65536, 17'd65536, 11'd9, 11'd9, 1'b0},
      1'b1, 17'd65536, 1'b0},
    '{OP_EPROD, '{16'h0005, 16'h0005, 17'd30000, 17'd50000, 11'd9, 11'd9, 1'b1},
      1'b0, 17'd0, 1'b0},
    '{OP_DPROD, '{16'h0006, 16'h0006, 17'd20000, 17'd65536, 11'd3, 11'd3, 1'b0},
      1'b1, 17'd20000, 1'b0},
    '{OP_DPROD, '{16'h0007, 16'h0007, 17'd65536, 17'd30000, 11'd3, 11'd3, 1'b0},
      1'b1, 17'd30000, 1'b0},
    '{OP_DPROD, '{16'h0008, 16'h0008, 17'd40000, 17'd50000, 11'd3, 11'd3, 1'b1},
      1'b1, 17'd0, 1'b0},
    '{OP_MAX,   '{16'h0009, 16'h0009, 17'd0, 17'h1FFFF, 11'd1, 11'd1, 1'b0},
      1'b1, 17'd65536, 1'b0},
    '{OP_MAX,   '{16'h000A, 16'h000A, 17'd12345, 17'd6789, 11'd1, 11'd1, 1'b1},
      1'b0, 17'd0, 1'b0},
    '{OP_PSUM,  '{16'h000B, 16'h000B, 17'd65536, 17'd65536, 11'd2, 11'd2, 1'b0},
      1'b1, 17'd65536, 1'b0},
    '{OP_PSUM,  '{16'h000C, 16'h000C, 17'd20000, 17'd30000, 11'd2, 11'd2, 1'b1},
      1'b0, 17'd0, 1'b0},
    '{OP_ESUM,  '{16'h000D, 16'h000D, 17'd65536, 17'd65536, 11'd4, 11'd4, 1'b0},
      1'b1, 17'd65536, 1'b0},
    '{OP_ESUM,  '{16'h000E, 16'h000E, 17'd0, 17'd0, 11'd4, 11'd4, 1'b0},
      1'b1, 17'd0, 1'b0},
    '{OP_ESUM,  '{16'h000F, 16'h000F, 17'd30000, 17'd40000, 11'd4, 11'd4, 1'b1},
      1'b0, 17'd0, 1'b0},
    '{OP_DSUM,  '{16'h0010, 16'h0010, 17'd0, 17'd45000, 11'd6, 11'd6, 1'b0},
      1'b1, 17'd45000, 1'b0},
    '{OP_DSUM,  '{16'h0011, 16'h0011, 17'd45000, 17'd0, 11'd6, 11'd6, 1'b0},
      1'b1, 17'd45000, 1'b0},
    '{OP_DSUM,  '{16'h0012, 16'h0012, 17'd1, 17'd1, 11'd6, 11'd6, 1'b0},
      1'b1, 17'd65536, 1'b0},
    '{OP_DSUM,  '{16'h0000, 16'hFFFF, 17'd1000, 17'd2000, 11'd6, 11'd6, 1'b1},
      1'b1, 17'd0, 1'b1}
  };

  fuzzy_norm_combiner uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key_a     (key_a),
    .key_b     (key_b),
    .degree_a  (degree_a),
    .degree_b  (degree_b),
    .count_a   (count_a),
    .count_b   (count_b),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_out   (key_out),
    .degree_out(degree_out),
    .mismatch  (mismatch),
    .last_out  (last_out)
  );

  always #4 clk = ~clk;

  function automatic bit [63:0] saturate(logic [DEG_W-1:0] d);
    return (d > FX_ONE) ? 64'(FX_ONE) : 64'(d);
  endfunction

  function automatic logic [DEG_W-1:0] norm_degree(op_t op, bit [63:0] a, bit [63:0] b);
    bit [63:0] one;
    bit [63:0] one2;
    bit [63:0] ab;
    bit [63:0] den;
    bit [63:0] r;
    one  = 64'(FX_ONE);
    one2 = one * one;
    ab   = a * b;
    case (op)
      OP_MIN:   r = (a < b) ? a : b;
      OP_PROD:  r = ab >> 16;
      OP_EPROD: begin
        den = 64'd2 * one2 + ab - (a + b) * one;
        r   = (ab * one) / den;
      end
      OP_DPROD: r = (b == one) ? a : ((a == one) ? b : 64'd0);
      OP_MAX:   r = (a > b) ? a : b;
      OP_PSUM:  r = ((a + b) * one - ab) >> 16;
      OP_ESUM:  r = ((a + b) * one2) / (one2 + ab);
      default:  r = (b == 64'd0) ? a : ((a == 64'd0) ? b : one);
    endcase
    if (r > one) r = one;
    return r[DEG_W-1:0];
  endfunction

  function automatic result_t combine_pair(op_t op, pair_t p);
    result_t r;
    logic    bad;
    bad = (p.key_a != p.key_b) || (p.cnt_a != p.cnt_b) ||
          (p.cnt_a > SET_SIZE_MAX) || (p.cnt_b > SET_SIZE_MAX);
    r.key      = p.key_a;
    r.degree   = bad ? '0 : norm_degree(op, saturate(p.deg_a), saturate(p.deg_b));
    r.mismatch = bad;
    r.last     = p.last;
    return r;
  endfunction

  function automatic logic [DEG_W-1:0] random_degree();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return FX_ONE;
      3:       return DEG_W'($urandom_range(131071, 65537));
      4:       return DEG_W'($urandom_range(15));
      default: return DEG_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    p.key_a = KEY_W'($urandom);
    p.key_b = p.key_a;
    p.deg_a = random_degree();
    p.deg_b = random_degree();
    p.cnt_a = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(1024, 1000))
                                       : CNT_W'($urandom_range(1024));
    p.cnt_b = p.cnt_a;
    p.last  = 1'($urandom_range(1));
    case ($urandom_range(19))
      0: p.key_b = p.key_a ^ KEY_W'($urandom_range(65535, 1));
      1: p.cnt_b = p.cnt_a ^ CNT_W'($urandom_range(2047, 1));
      2: begin
        p.cnt_a = CNT_W'($urandom_range(2047, 1025));
        p.cnt_b = p.cnt_a;
      end
      3: begin
        p.key_b = KEY_W'($urandom);
        p.cnt_b = CNT_W'($urandom);
      end
      default: ;
    endcase
    return p;
  endfunction

  // Called just after the clock rises; returns once the transfer has happened.
  task automatic send_pair(input pair_t p, input logic typed,
                           input logic [DEG_W-1:0] t_deg, input logic t_mis);
    result_t r;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    key_a    <= p.key_a;
    key_b    <= p.key_b;
    degree_a <= p.deg_a;
    degree_b <= p.deg_b;
    count_a  <= p.cnt_a;
    count_b  <= p.cnt_b;
    is_last  <= p.last;
    do @(posedge clk); while (in_stall);
    r = combine_pair(op_now, p);
    if (typed) begin
      r.degree   = t_deg;
      r.mismatch = t_mis;
    end
    pending_results.push_back(r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_operation(input op_t op);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= op;
    @(posedge clk);
    cfg_we   <= 1'b0;
    op_now   = op;
  endtask

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with none outstanding: key_out=%0h", key_out);
        fail_count++;
      end else begin
        head = pending_results.pop_front();
        if (key_out !== head.key) begin
          $error("key_out: expected %0h, got %0h", head.key, key_out);
          fail_count++;
        end
        if (degree_out !== head.degree) begin
          $error("degree_out: expected %0d, got %0d", head.degree, degree_out);
          fail_count++;
        end
        if (mismatch !== head.mismatch) begin
          $error("mismatch: expected %0b, got %0b", head.mismatch, mismatch);
          fail_count++;
        end
        if (last_out !== head.last) begin
          $error("last_out: expected %0b, got %0b", head.last, last_out);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[fuzzy_norm_combiner] ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // operation left at its reset value for the first rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op != op_now) set_operation(directed_rows[i].op);
      send_pair(directed_rows[i].pair, directed_rows[i].typed,
                directed_rows[i].exp_deg, directed_rows[i].exp_mis);
    end

    for (int k = 0; k < 8; k++) begin
      set_operation(op_t'(k));
      case (k % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 47; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 47; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (k == 5 && n == PHASE_ITEMS / 2) drain_results();
        send_pair(random_pair(), 1'b0, '0, 1'b0);
      end
    end

    drain_results();
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[fuzzy_norm_combiner] OK");
    end else begin
      $display("[fuzzy_norm_combiner] ERROR");
    end
    $finish;
  end

endmodule
